// ----- rtl/core/tstb_pkg.sv -----
package tstb_pkg;

  localparam int NUM_TIMERS = 32;
  localparam int IDX_W      = $clog2(NUM_TIMERS);
  localparam int CNT_W      = 32;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_CREATE = 2'd1;
  localparam logic [1:0] KIND_KBD    = 2'd2;
  localparam logic [1:0] KIND_MOUSE  = 2'd3;

  localparam logic [1:0] RES_EXPIRY  = 2'd0;
  localparam logic [1:0] RES_SUMMARY = 2'd1;
  localparam logic [1:0] RES_CREATE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_MODE = 2'd2;

  localparam logic [3:0] MODE_PERIODIC = 4'd2;
  localparam logic [3:0] MODE_MIN      = 4'd1;
  localparam logic [3:0] MODE_MAX      = 4'd10;

  localparam logic       CFG_TICK_HZ   = 1'b0;
  localparam logic       CFG_PROF_PER  = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] duration_ms;
    logic [3:0]  timer_mode;
    logic [7:0]  owner_thread;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [4:0]  timer_index;
    logic [7:0]  timer_owner;
    logic [1:0]  create_status;
    logic [31:0] tick_count;
    logic [31:0] uptime_ms;
    logic [31:0] uptime_seconds;
    logic        housekeeping_due;
    logic        profiler_due;
    logic [6:0]  keyboard_idle;
    logic [7:0]  mouse_idle;
    logic        last;
  } out_word_t;

endpackage

// ----- rtl/core/tick_software_timer_bank.sv -----
// channel  | signals                                  | word
// in       | in_valid_i / in_ready_o / in_data_i      | tick, create, keyboard, mouse
// out      | out_valid_o / out_ready_i / out_data_o   | expiry, tick summary, create answer
// config   | cfg_we_i / cfg_idx_i / cfg_wdata_i       | tick_hz, profiler_period
//
// one word at a time; in_ready_o is high only while the sequencer is idle
// a tick runs up to three passes of the shared 32-step radix-2 divider
// (ms per tick, seconds, profiler remainder), then walks the 32 slots one
// per cycle, holding on an expiring slot while the output register is full
// the housekeeping pulse comes from a mod-100 counter beside the tick count
// a create runs up to two divider passes
// the answers hold while the output register is full
module tick_software_timer_bank
  import tstb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_SUM  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  // divider jobs
  localparam logic [2:0] P_MPT  = 3'd0;
  localparam logic [2:0] P_SEC  = 3'd1;
  localparam logic [2:0] P_PROF = 3'd3;
  localparam logic [2:0] P_WDOG = 3'd4;
  localparam logic [2:0] P_CMPT = 3'd5;
  localparam logic [2:0] P_CCNT = 3'd6;

  logic [2:0]  state_q, phase_q;
  logic [9:0]  hz_q;
  logic [15:0] pp_q;
  logic [31:0] ticks_q, ms_q, sec_q;
  logic [6:0]  hk_cnt_q;
  logic [6:0]  kbd_q;
  logic [7:0]  mouse_q;
  logic        hk_q, prof_q;
  logic [9:0]  mpt_q;
  logic [NUM_TIMERS-1:0] used_q;

  // new timer held while its count is worked out
  logic [IDX_W-1:0] new_idx_q;
  logic [31:0]      new_ms_q;
  logic [7:0]       new_owner_q;
  logic             new_per_q;

  logic [IDX_W-1:0] idx_q;
  out_word_t        pend_q;

  // slot store, written only when a slot is taken, counts down or reloads
  logic             per_q   [NUM_TIMERS];
  logic [CNT_W-1:0] rem_q   [NUM_TIMERS];
  logic [CNT_W-1:0] rel_q   [NUM_TIMERS];
  logic [7:0]       owner_q [NUM_TIMERS];

  // shared divider
  logic [31:0] dvd_q;
  logic [15:0] dvs_q;
  logic [15:0] drem_q;
  logic [4:0]  dcnt_q;
  logic [16:0] dtrial;
  logic        dbit;
  logic [15:0] drem_d;
  logic [31:0] dquo_d;

  assign dtrial = {drem_q, dvd_q[31]};
  assign dbit   = (dtrial >= {1'b0, dvs_q});
  assign drem_d = dbit ? 16'(dtrial - {1'b0, dvs_q}) : dtrial[15:0];
  assign dquo_d = {dvd_q[30:0], dbit};

  // tick count lands on a multiple of 100, also when it wraps to zero
  logic hk_wrap;
  assign hk_wrap = (hk_cnt_q == 7'd99) || (ticks_q == '1);

  // output register
  logic      ov_q;
  out_word_t out_q;
  logic      can_emit;
  logic      ld;
  out_word_t ld_data;

  assign can_emit    = !ov_q || out_ready_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign in_ready_o  = (state_q == S_IDLE);

  // lowest free slot
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // create answer as first known; the slot index is filled in later
  out_word_t create_ans;
  always_comb begin
    create_ans             = '0;
    create_ans.result_kind = RES_CREATE;
    create_ans.last        = 1'b1;
    if (in_data_i.timer_mode < MODE_MIN || in_data_i.timer_mode > MODE_MAX) begin
      create_ans.create_status = ST_BAD_MODE;
    end else if (!free_found) begin
      create_ans.create_status = ST_FULL;
    end
  end

  // slot walk
  logic [CNT_W-1:0] cur_rem, cur_dec;
  logic             cur_live, cur_exp, walk_go;
  assign cur_rem  = rem_q[idx_q];
  assign cur_dec  = cur_rem - 1'b1;
  assign cur_live = used_q[idx_q] && (cur_rem != '0);
  assign cur_exp  = cur_live && (cur_dec == '0);
  assign walk_go  = (state_q == S_WALK) && (!cur_exp || can_emit);

  logic div_done, ccnt_done;
  assign div_done  = (state_q == S_DIV) && (dcnt_q == 5'd31);
  assign ccnt_done = div_done && (phase_q == P_CCNT);

  always_comb begin
    ld      = 1'b0;
    ld_data = '0;
    case (state_q)
      S_WALK: begin
        if (cur_exp && can_emit) begin
          ld                  = 1'b1;
          ld_data.result_kind = RES_EXPIRY;
          ld_data.timer_index = 5'(idx_q);
          ld_data.timer_owner = owner_q[idx_q];
        end
      end
      S_SUM: begin
        ld                       = can_emit;
        ld_data.result_kind      = RES_SUMMARY;
        ld_data.tick_count       = ticks_q;
        ld_data.uptime_ms        = ms_q;
        ld_data.uptime_seconds   = sec_q;
        ld_data.housekeeping_due = hk_q;
        ld_data.profiler_due     = prof_q;
        ld_data.keyboard_idle    = kbd_q;
        ld_data.mouse_idle       = mouse_q;
        ld_data.last             = 1'b1;
      end
      S_EMIT: begin
        ld      = can_emit;
        ld_data = pend_q;
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ld) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_q <= ld_data;
    end
  end

  // slot store writes
  always_ff @(posedge clk_i) begin
    if (ccnt_done) begin
      per_q[new_idx_q]   <= new_per_q;
      rem_q[new_idx_q]   <= dquo_d;
      rel_q[new_idx_q]   <= dquo_d;
      owner_q[new_idx_q] <= new_owner_q;
    end else if (walk_go && cur_live) begin
      rem_q[idx_q] <= (cur_exp && per_q[idx_q]) ? rel_q[idx_q] : cur_dec;
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (state_q == S_PREP) begin
      drem_q <= '0;
      dcnt_q <= '0;
      case (phase_q)
        P_MPT, P_CMPT: begin
          dvd_q <= 32'd1000;
          dvs_q <= 16'(hz_q);
        end
        P_SEC: begin
          dvd_q <= ticks_q;
          dvs_q <= 16'(hz_q);
        end
        P_PROF: begin
          dvd_q <= ticks_q;
          dvs_q <= pp_q;
        end
        default: begin
          dvd_q <= (new_ms_q < 32'(mpt_q)) ? 32'(mpt_q) : new_ms_q;
          dvs_q <= 16'(mpt_q);
        end
      endcase
    end else if (state_q == S_DIV) begin
      dvd_q  <= dquo_d;
      drem_q <= drem_d;
      dcnt_q <= dcnt_q + 5'd1;
    end
  end

  // sequencer and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= P_MPT;
      hz_q        <= 10'd100;
      pp_q        <= 16'd100;
      ticks_q     <= '0;
      ms_q        <= '0;
      sec_q       <= '0;
      hk_cnt_q    <= '0;
      kbd_q       <= '0;
      mouse_q     <= '0;
      hk_q        <= 1'b0;
      prof_q      <= 1'b0;
      mpt_q       <= 10'd1;
      used_q      <= '0;
      idx_q       <= '0;
      new_idx_q   <= '0;
      new_ms_q    <= '0;
      new_owner_q <= '0;
      new_per_q   <= 1'b0;
      pend_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_TICK_HZ) begin
          hz_q <= cfg_wdata_i[9:0];
        end else begin
          pp_q <= cfg_wdata_i;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (in_data_i.kind)
              KIND_TICK: begin
                ticks_q  <= ticks_q + 32'd1;
                hk_cnt_q <= hk_wrap ? 7'd0 : hk_cnt_q + 7'd1;
                hk_q     <= hk_wrap;
                prof_q   <= 1'b0;
                phase_q  <= P_MPT;
                state_q  <= S_PREP;
              end
              KIND_CREATE: begin
                pend_q <= create_ans;
                if (in_data_i.timer_mode < MODE_MIN || in_data_i.timer_mode > MODE_MAX) begin
                  state_q <= S_EMIT;
                end else if (!free_found) begin
                  state_q <= S_EMIT;
                end else begin
                  new_idx_q   <= free_idx;
                  new_ms_q    <= in_data_i.duration_ms;
                  new_owner_q <= in_data_i.owner_thread;
                  new_per_q   <= (in_data_i.timer_mode == MODE_PERIODIC);
                  phase_q     <= P_CMPT;
                  state_q     <= S_PREP;
                end
              end
              KIND_KBD: begin
                kbd_q <= '0;
              end
              default: begin
                mouse_q <= '0;
              end
            endcase
          end
        end
        S_PREP: begin
          case (phase_q)
            P_MPT: begin
              if (hz_q != '0) begin
                state_q <= S_DIV;
              end else begin
                phase_q <= P_PROF;
              end
            end
            P_PROF: begin
              if (pp_q != '0) begin
                state_q <= S_DIV;
              end else begin
                phase_q <= P_WDOG;
              end
            end
            P_WDOG: begin
              // idle watchdogs step every 100 ticks and wrap
              if (hk_q) begin
                kbd_q   <= (kbd_q >= 7'd100) ? 7'd0 : kbd_q + 7'd1;
                mouse_q <= (mouse_q >= 8'd200) ? 8'd0 : mouse_q + 8'd1;
              end
              idx_q   <= '0;
              state_q <= S_WALK;
            end
            P_CMPT: begin
              if (hz_q != '0 && hz_q <= 10'd1000) begin
                state_q <= S_DIV;
              end else begin
                mpt_q   <= 10'd1;
                phase_q <= P_CCNT;
              end
            end
            default: begin
              state_q <= S_DIV;
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_PREP;
            case (phase_q)
              P_MPT: begin
                ms_q    <= ms_q + dquo_d;
                phase_q <= P_SEC;
              end
              P_SEC: begin
                sec_q   <= dquo_d;
                phase_q <= P_PROF;
              end
              P_PROF: begin
                prof_q  <= (drem_d == '0);
                phase_q <= P_WDOG;
              end
              P_CMPT: begin
                mpt_q   <= dquo_d[9:0];
                phase_q <= P_CCNT;
              end
              default: begin
                used_q[new_idx_q]  <= 1'b1;
                pend_q.timer_index <= 5'(new_idx_q);
                state_q            <= S_EMIT;
              end
            endcase
          end
        end
        S_WALK: begin
          if (walk_go) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == IDX_W'(NUM_TIMERS - 1)) begin
              state_q <= S_SUM;
            end
          end
        end
        S_SUM, S_EMIT: begin
          if (can_emit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
